>>> sv/compact_target_decoder_assert.svh
// Assertion macros shared by the compact target decoder checkers.
`ifndef COMPACT_TARGET_DECODER_ASSERT_SVH
`define COMPACT_TARGET_DECODER_ASSERT_SVH

// The antecedent implies the consequent in the same cycle.
`define CTD_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The antecedent implies the consequent in the next cycle.
`define CTD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/ctd_pkg.sv
// Shared types and constants of the compact target decoder.
package ctd_pkg;

	localparam int unsigned WORD_W = 64;
	localparam int unsigned TARGET_W = 256;
	localparam int unsigned CFG_INDEX_W = 3;

	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_NEGATIVE    = 3'd1;
	localparam logic [2:0] ST_ZERO        = 3'd2;
	localparam logic [2:0] ST_OVERFLOW    = 3'd3;
	localparam logic [2:0] ST_NONCANON    = 3'd4;
	localparam logic [2:0] ST_ABOVE_LIMIT = 3'd5;

	localparam logic [CFG_INDEX_W-1:0] CFG_ENABLE = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_LIMIT3 = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_LIMIT2 = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_LIMIT1 = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_LIMIT0 = 3'd4;

	localparam logic [7:0] EXP_MAX  = 8'd34;
	localparam logic [7:0] EXP_WIDE = 8'd33;
	localparam logic [7:0] EXP_FULL = 8'd32;
	localparam logic [7:0] EXP_BASE = 8'd3;

	localparam logic [WORD_W-1:0] LIMIT3_RESET = 64'h7FFF_FF00_0000_0000;

	typedef struct packed {
		logic [2:0]  code;
		logic [4:0]  shift;
		logic [22:0] value;
	} front_t;

endpackage

>>> sv/ctd_front.sv
// Field decode, error classification and shift setup for one compact word.
module ctd_front (
	input  logic [31:0]     compact_bits,
	output ctd_pkg::front_t front
);

	logic [7:0]  expo;
	logic [22:0] mant;
	logic        hi_nz;
	logic        zero_target;
	logic        canon;
	logic [7:0]  shift_full;
	logic [2:0]  code;
	logic [4:0]  shift;
	logic [22:0] value;

	assign expo = compact_bits[31:24];
	assign mant = compact_bits[22:0];
	assign hi_nz = mant[22:16] != 7'd0;
	assign shift_full = expo - ctd_pkg::EXP_BASE;
	assign front = {code, shift, value};

	always_comb begin
		zero_target = (expo == 8'd0) || (expo == 8'd1 && !hi_nz) ||
			(expo == 8'd2 && mant[22:8] == 15'd0);
		canon = (hi_nz || mant[15]) && !(expo == 8'd1 && mant[15:0] != 16'd0) &&
			!(expo == 8'd2 && mant[7:0] != 8'd0);
	end

	always_comb begin
		if (compact_bits[23]) begin
			code = ctd_pkg::ST_NEGATIVE;
		end else if (mant == 23'd0) begin
			code = ctd_pkg::ST_ZERO;
		end else if (expo > ctd_pkg::EXP_MAX ||
				(mant[22:8] != 15'd0 && expo > ctd_pkg::EXP_WIDE) ||
				(hi_nz && expo > ctd_pkg::EXP_FULL)) begin
			code = ctd_pkg::ST_OVERFLOW;
		end else if (expo > ctd_pkg::EXP_FULL) begin
			code = ctd_pkg::ST_NONCANON;
		end else if (zero_target) begin
			code = ctd_pkg::ST_ZERO;
		end else if (!canon) begin
			code = ctd_pkg::ST_NONCANON;
		end else begin
			code = ctd_pkg::ST_OK;
		end
	end

	always_comb begin
		case (expo)
			8'd0: begin
				value = 23'd0;
				shift = 5'd0;
			end
			8'd1: begin
				value = {16'd0, mant[22:16]};
				shift = 5'd0;
			end
			8'd2: begin
				value = {8'd0, mant[22:8]};
				shift = 5'd0;
			end
			default: begin
				value = mant;
				shift = shift_full[4:0];
			end
		endcase
	end

endmodule

>>> sv/compact_target_decoder.sv
// Top level of the compact difficulty word decoder pipeline.
// Input channel: in_valid, in_ready and compact_bits carry one compact word.
// Output channel: out_valid, out_ready, status and target_word3..0 carry one
// result word for each input word, in order; the target is zero unless the
// status is ok.
// Configuration: cfg_write with cfg_index and cfg_data loads the limit check
// enable (index 0) or a limit word (indexes 1 to 4, word 3 first) at once.
// Other indexes are ignored. Write only while no word is in flight.
// One word is taken every cycle while the output is not stalled. The stages
// are decode, byte shift into 256 bits, per-word limit compare, and limit
// verdict with the output register.
// Reset clears all valid bits, enables the limit check and loads the default
// limit. When the receiver holds out_ready low with a result waiting, the
// whole pipeline holds and in_ready drops in the same cycle; nothing is lost.
module compact_target_decoder (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [31:0]                         compact_bits,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [2:0]                          status,
	output logic [ctd_pkg::WORD_W-1:0]          target_word3,
	output logic [ctd_pkg::WORD_W-1:0]          target_word2,
	output logic [ctd_pkg::WORD_W-1:0]          target_word1,
	output logic [ctd_pkg::WORD_W-1:0]          target_word0,
	input  logic                                cfg_write,
	input  logic [ctd_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [ctd_pkg::WORD_W-1:0]          cfg_data
);

	logic                            enable_q;
	logic [ctd_pkg::WORD_W-1:0]      limit_q [4];

	ctd_pkg::front_t                 front;
	logic                            adv;

	logic                            valid_s1;
	ctd_pkg::front_t                 front_s1;

	logic                            valid_s2;
	logic [2:0]                      code_s2;
	logic [ctd_pkg::TARGET_W-1:0]    target_s2;

	logic                            valid_s3;
	logic [2:0]                      code_s3;
	logic [ctd_pkg::TARGET_W-1:0]    target_s3;
	logic [3:0]                      lt_s3;
	logic [3:0]                      eq_s3;

	logic                            valid_s4;
	logic [2:0]                      code_s4;
	logic [ctd_pkg::TARGET_W-1:0]    target_s4;

	logic                            above;
	logic [2:0]                      final_code;

	ctd_front u_front (
		.compact_bits(compact_bits),
		.front       (front)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q   <= 1'b1;
			limit_q[3] <= ctd_pkg::LIMIT3_RESET;
			limit_q[2] <= '0;
			limit_q[1] <= '0;
			limit_q[0] <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				ctd_pkg::CFG_ENABLE: enable_q   <= cfg_data[0];
				ctd_pkg::CFG_LIMIT3: limit_q[3] <= cfg_data;
				ctd_pkg::CFG_LIMIT2: limit_q[2] <= cfg_data;
				ctd_pkg::CFG_LIMIT1: limit_q[1] <= cfg_data;
				ctd_pkg::CFG_LIMIT0: limit_q[0] <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign adv = !valid_s4 || out_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_comb begin
		above = lt_s3[3] || (eq_s3[3] && lt_s3[2]) || (eq_s3[3] && eq_s3[2] && lt_s3[1]) ||
			(eq_s3[3] && eq_s3[2] && eq_s3[1] && lt_s3[0]);
		if (code_s3 == ctd_pkg::ST_OK && enable_q && above) begin
			final_code = ctd_pkg::ST_ABOVE_LIMIT;
		end else begin
			final_code = code_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			front_s1 <= front;

			code_s2   <= front_s1.code;
			target_s2 <= ctd_pkg::TARGET_W'(front_s1.value) << {front_s1.shift, 3'b000};

			code_s3   <= code_s2;
			target_s3 <= target_s2;
			for (int k = 0; k < 4; k++) begin
				lt_s3[k] <= limit_q[k] < target_s2[k*ctd_pkg::WORD_W +: ctd_pkg::WORD_W];
				eq_s3[k] <= limit_q[k] == target_s2[k*ctd_pkg::WORD_W +: ctd_pkg::WORD_W];
			end

			code_s4   <= final_code;
			target_s4 <= (final_code == ctd_pkg::ST_OK) ? target_s3 : '0;
		end
	end

	assign out_valid    = valid_s4;
	assign status       = code_s4;
	assign target_word3 = target_s4[4*ctd_pkg::WORD_W-1:3*ctd_pkg::WORD_W];
	assign target_word2 = target_s4[3*ctd_pkg::WORD_W-1:2*ctd_pkg::WORD_W];
	assign target_word1 = target_s4[2*ctd_pkg::WORD_W-1:ctd_pkg::WORD_W];
	assign target_word0 = target_s4[ctd_pkg::WORD_W-1:0];

endmodule

>>> sv/ctd_checker.sv
// Port-level assertions for the compact target decoder and their binding.
`include "compact_target_decoder_assert.svh"

module ctd_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_ready,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [2:0]                      status,
	input logic [ctd_pkg::WORD_W-1:0]      target_word3,
	input logic [ctd_pkg::WORD_W-1:0]      target_word2,
	input logic [ctd_pkg::WORD_W-1:0]      target_word1,
	input logic [ctd_pkg::WORD_W-1:0]      target_word0
);

	logic target_zero;

	assign target_zero = (target_word3 | target_word2 | target_word1 | target_word0) == '0;

	`CTD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status), "result word dropped while stalled")
	`CTD_ASSERT_SAME(a_err_zero, out_valid && status != ctd_pkg::ST_OK, target_zero, "error word carries a target")
	`CTD_ASSERT_SAME(a_ok_nonzero, out_valid && status == ctd_pkg::ST_OK, !target_zero, "accepted word has zero target")
	`CTD_ASSERT_SAME(a_no_bubble, !out_valid || out_ready, in_ready, "input held back with free output")

endmodule

bind compact_target_decoder ctd_checker u_ctd_checker (.*);

>>> bench/compact_target_decoder_test.sv
// Self-checking testbench for the compact target decoder with directed and random words.
module compact_target_decoder_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_LENGTH = 200;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [2:0]                   status;
		logic [ctd_pkg::TARGET_W-1:0] target;
	} verdict_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [31:0] compact_bits = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [2:0] status;
	logic [ctd_pkg::WORD_W-1:0] target_word3;
	logic [ctd_pkg::WORD_W-1:0] target_word2;
	logic [ctd_pkg::WORD_W-1:0] target_word1;
	logic [ctd_pkg::WORD_W-1:0] target_word0;
	logic cfg_write = 1'b0;
	logic [ctd_pkg::CFG_INDEX_W-1:0] cfg_index = ctd_pkg::CFG_ENABLE;
	logic [ctd_pkg::WORD_W-1:0] cfg_data = '0;

	logic limit_on = 1'b1;
	logic [ctd_pkg::TARGET_W-1:0] limit_value =
		{ctd_pkg::LIMIT3_RESET, {(3 * ctd_pkg::WORD_W){1'b0}}};
	logic [31:0] near_word = 32'h207F_FFFF;

	logic [31:0] queued_words[$];
	verdict_t pending_verdicts[$];

	int words_sent = 0;
	int results_checked = 0;
	int mismatches = 0;
	int settings_used = 1;
	int status_seen[8] = '{default: 0};
	int cycle_count = 0;

	logic offer_next;
	int burst_left = 8;
	int gap_left = 0;
	int hold_left = 0;
	int pattern_age = 0;
	logic [15:0] ready_mask = 16'hFFFF;
	verdict_t want;

	compact_target_decoder uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.compact_bits (compact_bits),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.target_word3 (target_word3),
		.target_word2 (target_word2),
		.target_word1 (target_word1),
		.target_word0 (target_word0),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic verdict_t expand_compact(input logic [31:0] word);
		verdict_t v;
		logic [7:0] expo;
		logic [22:0] mant;
		logic [ctd_pkg::TARGET_W-1:0] value;
		logic [23:0] top;
		logic [31:0] recoded;
		int e;
		int nbytes;
		v.status = ctd_pkg::ST_OK;
		v.target = '0;
		expo = word[31:24];
		mant = word[22:0];
		e = int'(expo);
		if (word[23]) begin
			v.status = ctd_pkg::ST_NEGATIVE;
		end else if (mant == '0) begin
			v.status = ctd_pkg::ST_ZERO;
		end else if (expo > ctd_pkg::EXP_MAX || (mant > 23'hFF && expo > ctd_pkg::EXP_WIDE)
				|| (mant > 23'hFFFF && expo > ctd_pkg::EXP_FULL)) begin
			v.status = ctd_pkg::ST_OVERFLOW;
		end else if (expo > ctd_pkg::EXP_FULL) begin
			v.status = ctd_pkg::ST_NONCANON;
		end else begin
			if (expo <= ctd_pkg::EXP_BASE)
				value = ctd_pkg::TARGET_W'(mant) >> (8 * (3 - e));
			else
				value = ctd_pkg::TARGET_W'(mant) << (8 * (e - 3));
			if (value == '0) begin
				v.status = ctd_pkg::ST_ZERO;
			end else begin
				nbytes = 32;
				while (value[8 * nbytes - 1 -: 8] == 8'h00)
					nbytes--;
				if (nbytes <= 3)
					top = 24'(value << (8 * (3 - nbytes)));
				else
					top = 24'(value >> (8 * (nbytes - 3)));
				if (top[23]) begin
					top = top >> 8;
					nbytes++;
				end
				recoded = {8'(nbytes), top};
				if (recoded != word)
					v.status = ctd_pkg::ST_NONCANON;
				else if (limit_on && (limit_value == '0 || limit_value < value))
					v.status = ctd_pkg::ST_ABOVE_LIMIT;
				else
					v.target = value;
			end
		end
		return v;
	endfunction

	function automatic logic [31:0] pick_word();
		int roll;
		logic [7:0] e;
		logic [22:0] m;
		logic [31:0] w;
		roll = $urandom_range(0, 99);
		e = 8'($urandom_range(1, 32));
		m = 23'($urandom);
		if (roll < 35) begin
			case ($urandom_range(0, 2))
				0: m[22:16] = 7'($urandom_range(1, 127));
				1: begin
					m[22:16] = '0;
					m[15] = 1'b1;
				end
				default: ;
			endcase
			if (e == 8'd1)
				m[15:0] = '0;
			else if (e == 8'd2)
				m[7:0] = '0;
			w = {e, 1'b0, m};
		end else if (roll < 50) begin
			m = near_word[22:0] + 23'($urandom_range(0, 4)) - 23'd2;
			w = {near_word[31:24], 1'b0, m};
		end else if (roll < 60) begin
			if ($urandom_range(0, 3) == 0)
				e = 8'($urandom_range(33, 255));
			else
				e = 8'($urandom_range(32, 40));
			m = m >> $urandom_range(0, 22);
			w = {e, 1'b0, m};
		end else if (roll < 70) begin
			e = 8'($urandom_range(0, 4));
			w = {e, 1'b0, m};
		end else if (roll < 75) begin
			w = {8'($urandom), 1'($urandom), 23'd0};
		end else if (roll < 82) begin
			w = 32'($urandom);
			w[23] = 1'b1;
		end else begin
			w = 32'($urandom);
		end
		return w;
	endfunction

	task automatic set_reg(input logic [ctd_pkg::CFG_INDEX_W-1:0] idx,
			input logic [ctd_pkg::WORD_W-1:0] data);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			ctd_pkg::CFG_ENABLE: limit_on = data[0];
			ctd_pkg::CFG_LIMIT3: limit_value[255:192] = data;
			ctd_pkg::CFG_LIMIT2: limit_value[191:128] = data;
			ctd_pkg::CFG_LIMIT1: limit_value[127:64] = data;
			ctd_pkg::CFG_LIMIT0: limit_value[63:0] = data;
			default: ;
		endcase
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic set_limit(input logic [ctd_pkg::TARGET_W-1:0] lim);
		set_reg(ctd_pkg::CFG_LIMIT3, lim[255:192]);
		set_reg(ctd_pkg::CFG_LIMIT2, lim[191:128]);
		set_reg(ctd_pkg::CFG_LIMIT1, lim[127:64]);
		set_reg(ctd_pkg::CFG_LIMIT0, lim[63:0]);
		settings_used++;
	endtask

	task automatic drain();
		do
			@(negedge clk);
		while (queued_words.size() != 0 || in_valid || pending_verdicts.size() != 0);
	endtask

	task automatic run_random(input int count);
		repeat (count)
			queued_words.push_back(pick_word());
		drain();
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			compact_bits <= '0;
		end else begin
			offer_next = in_valid && !in_ready;
			if (in_valid && in_ready) begin
				pending_verdicts.push_back(expand_compact(compact_bits));
				words_sent++;
			end
			if (!offer_next) begin
				if (gap_left != 0) begin
					gap_left--;
				end else if (queued_words.size() != 0) begin
					compact_bits <= queued_words.pop_front();
					offer_next = 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = ($urandom_range(0, 7) == 0) ? 120 : $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end
				end
			end
			in_valid <= offer_next;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (pending_verdicts.size() == 0) begin
					if (mismatches < MAX_REPORTS)
						$display("%0t: result word arrived with nothing expected", $realtime);
					mismatches++;
				end else begin
					want = pending_verdicts.pop_front();
					if (status !== want.status || target_word3 !== want.target[255:192]
							|| target_word2 !== want.target[191:128]
							|| target_word1 !== want.target[127:64]
							|| target_word0 !== want.target[63:0]) begin
						if (mismatches < MAX_REPORTS)
							$display("%0t: result %0d expected status %0d target %h, %s %0d target %h",
								$realtime, results_checked, want.status, want.target,
								"got status", status,
								{target_word3, target_word2, target_word1, target_word0});
						mismatches++;
					end
					status_seen[want.status]++;
				end
				results_checked++;
				if (results_checked == 500 || results_checked == 1500)
					hold_left = HOLD_LENGTH;
			end
			if (hold_left != 0)
				hold_left--;
			if (pattern_age == 0) begin
				pattern_age = 48;
				case ($urandom_range(0, 3))
					0: ready_mask = 16'hFFFF;
					1: ready_mask = 16'($urandom | $urandom);
					2: ready_mask = 16'($urandom);
					default: ready_mask = 16'($urandom & $urandom) | 16'h0001;
				endcase
			end else begin
				pattern_age--;
			end
			ready_mask = {ready_mask[14:0], ready_mask[15]};
			out_ready <= (hold_left == 0) && ready_mask[0];
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("compact_target_decoder: mismatch");
			$finish;
		end
	end

	initial begin
		logic [7:0] ne;
		logic [22:0] nm;
		logic [ctd_pkg::TARGET_W-1:0] near_limit;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Default limit taken from reset; the limit itself is encoded as 0x207FFFFF.
		queued_words = '{
			32'h0000_0000, 32'hFFFF_FFFF, 32'h0080_0000, 32'h2200_00FF, 32'h2200_0100,
			32'h2300_0001, 32'h2100_FFFF, 32'h2101_0000, 32'h2100_0100, 32'h207F_FFFF,
			32'h207F_FFFE, 32'h2000_FFFF, 32'h1D00_FFFF, 32'h0112_0000, 32'h0112_3456,
			32'h0100_FFFF, 32'h0200_8000, 32'h0212_3400, 32'h0312_3456, 32'h0300_0001,
			32'h047F_FFFF, 32'h0400_8000, 32'h2100_0001, 32'hFF7F_FFFF, 32'h0000_0001
		};
		drain();

		set_reg(ctd_pkg::CFG_ENABLE, 64'hFFFF_FFFF_FFFF_FFFE);
		set_limit({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom});
		run_random(360);

		set_reg(ctd_pkg::CFG_ENABLE, 64'd1);
		set_limit({ctd_pkg::TARGET_W{1'b1}});
		run_random(360);

		set_limit('0);
		run_random(200);

		ne = 8'($urandom_range(20, 32));
		nm = 23'($urandom);
		nm[22:16] = 7'($urandom_range(1, 127));
		near_word = {ne, 1'b0, nm};
		near_limit = ctd_pkg::TARGET_W'(nm) << (8 * (int'(ne) - 3));
		set_limit(near_limit);
		for (int i = int'(ctd_pkg::CFG_LIMIT0) + 1; i < (1 << ctd_pkg::CFG_INDEX_W); i++)
			set_reg(ctd_pkg::CFG_INDEX_W'(i), {$urandom, $urandom});
		queued_words.push_back(near_word);
		queued_words.push_back({ne, 1'b0, nm + 23'd1});
		queued_words.push_back({ne, 1'b0, nm - 23'd1});
		run_random(360);

		near_word = 32'h207F_FFFF;
		set_limit({ctd_pkg::LIMIT3_RESET, {(3 * ctd_pkg::WORD_W){1'b0}}});
		run_random(540);

		repeat (8) @(negedge clk);
		$display("Sent %0d compact words under %0d limit settings; %0d results checked, %0d bad.",
			words_sent, settings_used, results_checked, mismatches);
		$display("Status mix: ok %0d, negative %0d, zero %0d, overflow %0d,",
			status_seen[ctd_pkg::ST_OK], status_seen[ctd_pkg::ST_NEGATIVE],
			status_seen[ctd_pkg::ST_ZERO], status_seen[ctd_pkg::ST_OVERFLOW]);
		$display("  non-canonical %0d, above limit %0d.",
			status_seen[ctd_pkg::ST_NONCANON], status_seen[ctd_pkg::ST_ABOVE_LIMIT]);
		if (mismatches == 0)
			$display("compact_target_decoder: match");
		else
			$display("compact_target_decoder: mismatch");
		$finish;
	end

endmodule
